// ----- rtl/stbs_pkg.sv -----
// Package with shared types and constants of the sortable table block.
`timescale 1ns / 1ps
package stbs_pkg;
	localparam int Capacity = 256;
	localparam int AddrW = $clog2(Capacity);
	localparam int CountW = AddrW + 1;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP = 2'd1,
		OP_SORT = 2'd2,
		OP_SEARCH = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_POP_EMPTY = 2'd2,
		ST_PUSH_FULL = 2'd3
	} status_t;

	// Datapath commands issued by the controller in one cycle.
	typedef struct packed {
		logic load_req;     // capture opcode and operand
		logic push_wr;      // write operand at count, count+1
		logic pop_dec;      // count-1, read top entry
		logic rd_mid;       // read entry at midpoint of lo/hi
		logic srch_init;    // lo=0, hi=count-1
		logic srch_step;    // compare read data, narrow lo/hi
		logic sort_init;    // i=1
		logic rd_key;       // read entries[i], j=i
		logic key_cap;      // capture key from read data
		logic rd_prev;      // read entries[j-1]
		logic shift_wr;     // entries[j]=read data, j--
		logic key_wr;       // entries[j]=key, i++
		logic res_pop;      // result from read data
		logic res_status;   // result with status only
		logic res_found;    // result from search hit
		status_t status;
	} stbs_cmd_t;

	// Datapath status seen by the controller.
	typedef struct packed {
		opcode_t op;
		logic empty;
		logic full;
		logic srch_done;    // lo > hi
		logic hit;          // read data equals operand
		logic sort_done;    // i >= count
		logic j_zero;
		logic prev_gt;      // read data greater than key
		logic out_busy;     // output register holds a result
	} stbs_stat_t;
endpackage

// ----- rtl/stbs_datapath.sv -----
// Datapath of the sortable table: memory, count, search and sort registers, output register.
`timescale 1ns / 1ps
module stbs_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic [33:0] in_data,
	input  stbs_pkg::stbs_cmd_t cmd,
	output stbs_pkg::stbs_stat_t stat,
	output logic out_valid,
	input  logic out_ready,
	output logic [47:0] out_data
);
	import stbs_pkg::*;

	logic signed [31:0] mem [Capacity];
	logic signed [31:0] rd_q;
	opcode_t op_q;
	logic signed [31:0] val_q;
	logic signed [31:0] key_q;
	logic [CountW-1:0] count_q;
	logic signed [CountW:0] lo_q, hi_q;
	logic [CountW-1:0] i_q, j_q;
	logic [AddrW-1:0] mid_q;
	logic [AddrW-1:0] rd_addr, wr_addr;
	logic signed [31:0] wr_data;
	logic wr_en, rd_en;
	logic signed [CountW:0] sum;
	logic valid_q;
	logic [31:0] res_val_q;
	logic [7:0] res_idx_q;
	status_t res_st_q;

	assign sum = lo_q + hi_q;

	always_comb begin
		rd_en = 1'b1;
		rd_addr = count_q[AddrW-1:0];
		if (cmd.pop_dec) begin
			rd_addr = AddrW'(count_q - 1'b1);
		end else if (cmd.rd_mid) begin
			rd_addr = sum[AddrW:1];
		end else if (cmd.rd_key) begin
			rd_addr = i_q[AddrW-1:0];
		end else if (cmd.rd_prev) begin
			rd_addr = AddrW'(j_q - 1'b1);
		end else begin
			rd_en = 1'b0;
		end
		wr_en = cmd.push_wr | cmd.shift_wr | cmd.key_wr;
		wr_addr = j_q[AddrW-1:0];
		wr_data = rd_q;
		if (cmd.push_wr) begin
			wr_addr = count_q[AddrW-1:0];
			wr_data = val_q;
		end else if (cmd.key_wr) begin
			wr_data = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q <= opcode_t'(in_data[1:0]);
			val_q <= in_data[33:2];
		end
		if (cmd.rd_mid) begin
			mid_q <= sum[AddrW:1];
		end
		if (cmd.key_cap) begin
			key_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			j_q <= '0;
			valid_q <= 1'b0;
			res_val_q <= '0;
			res_idx_q <= '0;
			res_st_q <= ST_OK;
		end else begin
			if (cmd.push_wr) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.srch_init) begin
				lo_q <= '0;
				hi_q <= (CountW+1)'($signed({2'b00, count_q}) - 1);
			end
			if (cmd.srch_step) begin
				if (rd_q < val_q) begin
					lo_q <= (CountW+1)'($signed({2'b00, mid_q}) + 1);
				end else begin
					hi_q <= (CountW+1)'($signed({2'b00, mid_q}) - 1);
				end
			end
			if (cmd.sort_init) begin
				i_q <= CountW'(1);
			end
			if (cmd.rd_key) begin
				j_q <= i_q;
			end
			if (cmd.shift_wr) begin
				j_q <= j_q - 1'b1;
			end
			if (cmd.key_wr) begin
				i_q <= i_q + 1'b1;
			end
			if (out_valid && out_ready) begin
				valid_q <= 1'b0;
			end
			if (cmd.res_pop || cmd.res_status || cmd.res_found) begin
				valid_q <= 1'b1;
				res_st_q <= cmd.status;
				res_val_q <= cmd.res_pop ? rd_q : '0;
				res_idx_q <= cmd.res_found ? 8'(mid_q) : '0;
			end
		end
	end

	assign stat.op = op_q;
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == CountW'(Capacity));
	assign stat.srch_done = (lo_q > hi_q);
	assign stat.hit = (rd_q == val_q);
	assign stat.sort_done = (i_q >= count_q);
	assign stat.j_zero = (j_q == '0);
	assign stat.prev_gt = (rd_q > key_q);
	assign stat.out_busy = valid_q;

	assign out_valid = valid_q;
	assign out_data = {6'b0, res_st_q, res_idx_q, res_val_q};

	ap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(Capacity)) else $error("count beyond capacity");
	ap_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !stat.full) else $error("push on full table");
	ap_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_dec |-> !stat.empty) else $error("pop on empty table");
	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_pop || cmd.res_status || cmd.res_found) |-> !valid_q)
		else $error("result overwritten");
endmodule

// ----- rtl/stbs_ctrl.sv -----
// Controller state machine of the sortable table.
`timescale 1ns / 1ps
module stbs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  stbs_pkg::stbs_stat_t stat,
	output stbs_pkg::stbs_cmd_t cmd
);
	import stbs_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_DISP   = 11'b00000000010,
		S_POPRD  = 11'b00000000100,
		S_SRCH   = 11'b00000001000,
		S_SCMP   = 11'b00000010000,
		S_SORT   = 11'b00000100000,
		S_KEY    = 11'b00001000000,
		S_PREV   = 11'b00010000000,
		S_PCMP   = 11'b00100000000,
		S_WAIT   = 11'b01000000000,
		S_RES    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (!stat.out_busy) begin
					unique case (stat.op)
						OP_PUSH: begin
							if (stat.full) begin
								cmd.res_status = 1'b1;
								cmd.status = ST_PUSH_FULL;
							end else begin
								cmd.push_wr = 1'b1;
								cmd.res_status = 1'b1;
							end
							state_d = S_IDLE;
						end
						OP_POP: begin
							if (stat.empty) begin
								cmd.res_status = 1'b1;
								cmd.status = ST_POP_EMPTY;
								state_d = S_IDLE;
							end else begin
								cmd.pop_dec = 1'b1;
								state_d = S_POPRD;
							end
						end
						OP_SORT: begin
							cmd.sort_init = 1'b1;
							state_d = S_SORT;
						end
						OP_SEARCH: begin
							cmd.srch_init = 1'b1;
							state_d = S_SRCH;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_POPRD: begin
				cmd.res_pop = 1'b1;
				state_d = S_IDLE;
			end
			S_SRCH: begin
				if (stat.srch_done) begin
					cmd.res_status = 1'b1;
					cmd.status = ST_NOT_FOUND;
					state_d = S_IDLE;
				end else begin
					cmd.rd_mid = 1'b1;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				if (stat.hit) begin
					cmd.res_found = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.srch_step = 1'b1;
					state_d = S_SRCH;
				end
			end
			S_SORT: begin
				if (stat.sort_done) begin
					cmd.res_status = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_key = 1'b1;
					state_d = S_KEY;
				end
			end
			S_KEY: begin
				cmd.key_cap = 1'b1;
				state_d = S_PREV;
			end
			S_PREV: begin
				if (stat.j_zero) begin
					cmd.key_wr = 1'b1;
					state_d = S_SORT;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d = S_PCMP;
				end
			end
			S_PCMP: begin
				if (stat.prev_gt) begin
					cmd.shift_wr = 1'b1;
					state_d = S_PREV;
				end else begin
					cmd.key_wr = 1'b1;
					state_d = S_SORT;
				end
			end
			S_WAIT: state_d = S_IDLE;
			S_RES: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	ap_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_DISP) else $error("request not dispatched");
	ap_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.res_pop, cmd.res_status, cmd.res_found}) <= 1)
		else $error("two results at once");
endmodule

// ----- rtl/sortable_table_with_binary_search_top.sv -----
// Top level of the sortable table with binary search.
//
// Channel   Dir  Fields
// s_axis    in   tdata[1:0] opcode, tdata[33:2] operand_value
// m_axis    out  tdata[31:0] result_value, [39:32] found_index, [41:40] status
//
// Search probes the midpoint through the one memory read port, reading in S_SRCH and
// comparing in S_SCMP until a hit or lo > hi. Sort is an insertion sort over
// that same port, reading each key and shifting larger entries up. Reset clears the count
// and control; entries are undefined until pushed. One request is worked at a time,
// and a held result in the output register stalls the next request at dispatch.
`timescale 1ns / 1ps
module sortable_table_with_binary_search_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // opcode, operand_value
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata    // result_value, found_index, status
);
	import stbs_pkg::*;

	stbs_cmd_t cmd;
	stbs_stat_t stat;

	stbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat(stat),
		.cmd(cmd)
	);

	stbs_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(s_axis_tdata[33:0]),
		.cmd(cmd),
		.stat(stat),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata)
	);
endmodule

// ----- tb/tb_checker.sv -----
// Checker that watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module tb_checker
	import stbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [31:0] value;
		logic [7:0] index;
		status_t status;
	} table_result_t;

	logic signed [31:0] table_mem [Capacity];
	int table_count;
	table_result_t result_fifo[$];

	initial begin
		fail_count = 0;
		table_count = 0;
	end

	assign pending = result_fifo.size();

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic table_result_t apply_request(input opcode_t op,
			input logic signed [31:0] operand);
		table_result_t r;
		int lo, hi, mid, j;
		logic signed [31:0] key;
		r = '{value: '0, index: '0, status: ST_OK};
		case (op)
			OP_PUSH: begin
				if (table_count >= Capacity) r.status = ST_PUSH_FULL;
				else begin
					table_mem[table_count] = operand;
					table_count++;
				end
			end
			OP_POP: begin
				if (table_count == 0) r.status = ST_POP_EMPTY;
				else begin
					table_count--;
					r.value = table_mem[table_count];
				end
			end
			OP_SORT: begin
				for (int i = 1; i < table_count; i++) begin
					key = table_mem[i];
					j = i;
					while (j > 0 && table_mem[j-1] > key) begin
						table_mem[j] = table_mem[j-1];
						j--;
					end
					table_mem[j] = key;
				end
			end
			default: begin
				lo = 0;
				hi = table_count - 1;
				r.status = ST_NOT_FOUND;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (table_mem[mid] == operand) begin
						r.status = ST_OK;
						r.index = mid[7:0];
						break;
					end
					if (table_mem[mid] < operand) lo = mid + 1;
					else hi = mid - 1;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		table_result_t want, got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				result_fifo.push_back(apply_request(opcode_t'(s_axis_tdata[1:0]),
					s_axis_tdata[33:2]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{value: m_axis_tdata[31:0], index: m_axis_tdata[39:32],
					status: status_t'(m_axis_tdata[41:40])};
				if (result_fifo.size() == 0) report_mismatch("unexpected", 48'(got), '0);
				else begin
					want = result_fifo.pop_front();
					if (got.value != want.value)
						report_mismatch("result_value", 48'(got.value), 48'(want.value));
					if (got.index != want.index)
						report_mismatch("found_index", 48'(got.index), 48'(want.index));
					if (got.status != want.status)
						report_mismatch("status", 48'(got.status), 48'(want.status));
				end
			end
		end
	end
endmodule

// ----- tb/tb_top.sv -----
// Top of the testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
	import stbs_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;
	int fail_count;
	int pending;
	int quiet_cycles;
	bit calm = 0;
	bit hold_off = 0;

	sortable_table_with_binary_search_top uut (.*);

	tb_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 300000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_request(input opcode_t op, input logic [31:0] operand);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'd0, operand, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'(int'($urandom_range(0, 15)) - 8);
			default: return $urandom;
		endcase
	endfunction

	// Receiver stalls: random bursts, one long hold-off, none when calm.
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			if (!calm && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 18);
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
		end
	end

	initial begin
		int n;
		opcode_t op;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		@(posedge arst_n);
		@(posedge clk);
		send_request(OP_POP, 32'h0);
		send_request(OP_SEARCH, 32'h0);
		send_request(OP_SORT, 32'h0);
		send_request(OP_PUSH, 32'h7fff_ffff);
		send_request(OP_SORT, 32'h0);
		send_request(OP_SEARCH, 32'h7fff_ffff);
		send_request(OP_PUSH, 32'h8000_0000);
		send_request(OP_PUSH, 32'h0000_0000);
		send_request(OP_PUSH, 32'hffff_ffff);
		send_request(OP_PUSH, 32'h5555_5555);
		send_request(OP_PUSH, 32'haaaa_aaaa);
		send_request(OP_SEARCH, 32'hffff_ffff);
		send_request(OP_SORT, 32'h0);
		send_request(OP_SEARCH, 32'h8000_0000);
		send_request(OP_SEARCH, 32'h7fff_ffff);
		send_request(OP_SEARCH, 32'h1234_5678);
		send_request(OP_POP, 32'hffff_ffff);
		hold_off = 1;
		// Fill the table to capacity, push on full, then sort, search and drain it.
		for (int i = 0; i < Capacity + 2; i++) send_request(OP_PUSH, $urandom);
		send_request(OP_SORT, 32'h0);
		for (int i = 0; i < 40; i++) send_request(OP_SEARCH, pick_value());
		for (int i = 0; i < Capacity + 2; i++) send_request(OP_POP, 32'h0);
		n = 0;
		while (n < 1100) begin
			if (n > 950) calm = 1;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: op = OP_PUSH;
				7, 8, 9, 10: op = OP_POP;
				11: op = OP_SORT;
				default: op = OP_SEARCH;
			endcase
			send_request(op, pick_value());
			n++;
		end
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
